// ===== rtl/core/gosd_pkg.sv =====
// ----------------------------------------------------------------------------
// gosd_pkg
// Shared types, codes and helpers for the glyph outline segment decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gosd_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_CMDS  = 3;
  localparam int CNT_W     = 2;

  typedef logic signed [COORD_W-1:0] gosd_coord_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEN_X   = 2'd0,
    CFG_PEN_Y   = 2'd1,
    CFG_FILL_CW = 2'd2
  } gosd_cfg_idx_t;

  // Drawing command codes
  typedef enum logic [2:0] {
    CMD_START       = 3'd0,
    CMD_LINE        = 3'd1,
    CMD_QUAD        = 3'd2,
    CMD_CUBIC       = 3'd3,
    CMD_CLOSE_LINE  = 3'd4,
    CMD_CLOSE_QUAD  = 3'd5,
    CMD_CLOSE_CUBIC = 3'd6
  } gosd_cmd_code_t;

  // Contour walk phases
  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_ON    = 4'b0010,
    PH_CTRL1 = 4'b0100,
    PH_CTRL2 = 4'b1000
  } gosd_phase_t;

  typedef struct packed {
    gosd_coord_t point_x;
    gosd_coord_t point_y;
    logic        on_curve;
    logic        cubic_control;
    logic        contour_end;
  } gosd_point_t;

  typedef struct packed {
    gosd_cmd_code_t command;
    gosd_coord_t    end_x;
    gosd_coord_t    end_y;
    gosd_coord_t    first_ctrl_x;
    gosd_coord_t    first_ctrl_y;
    gosd_coord_t    second_ctrl_x;
    gosd_coord_t    second_ctrl_y;
    logic           clockwise_fill;
    logic           last_of_run;
  } gosd_cmd_t;

  // Commands produced by one point, oldest in slot 0
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    gosd_cmd_t [MAX_CMDS-1:0]  cmds;
  } gosd_batch_t;

  // Result queue status toward the decoder
  typedef struct packed {
    logic             load_ok;
    logic [CNT_W-1:0] count;
  } gosd_drain_stat_t;

  // Wrapped sum, arithmetic shift right by one
  function automatic gosd_coord_t gosd_mid(input gosd_coord_t a, input gosd_coord_t b);
    logic [COORD_W-1:0] s;
    s = a + b;
    return gosd_coord_t'({s[COORD_W-1], s[COORD_W-1:1]});
  endfunction

  function automatic gosd_cmd_t gosd_make_cmd(
    input gosd_cmd_code_t code,
    input gosd_coord_t    ex,
    input gosd_coord_t    ey,
    input gosd_coord_t    c1x,
    input gosd_coord_t    c1y,
    input gosd_coord_t    c2x,
    input gosd_coord_t    c2y,
    input logic           cw
  );
    gosd_cmd_t c;
    c.command        = code;
    c.end_x          = ex;
    c.end_y          = ey;
    c.first_ctrl_x   = c1x;
    c.first_ctrl_y   = c1y;
    c.second_ctrl_x  = c2x;
    c.second_ctrl_y  = c2y;
    c.clockwise_fill = cw;
    c.last_of_run    = 1'b0;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/glyph_outline_segment_decoder_top.sv =====
// ----------------------------------------------------------------------------
// glyph_outline_segment_decoder_top
// Turns a stream of tagged outline points into drawing commands.
//
//   Port group | Dir | Handshake        | Carries
//   in_*       | in  | valid / ready    | one outline point (gosd_point_t)
//   out_*      | out | valid / ready    | one drawing command (gosd_cmd_t)
//   cfg_*      | in  | write enable     | pen offset, fill direction
//
// A point yielding zero or one command passes at one point per cycle while
// the output is not stalled; a point yielding several commands holds the
// result queue until each has left, and later points wait meanwhile. The
// first command passes the point register, then the result queue. Reset
// is synchronous: the phase returns to awaiting a contour start and both
// stages empty. A stalled output holds the queue; the point register takes
// one more point and then holds in_ready low until the queue can load again.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_outline_segment_decoder_top
  import gosd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire gosd_point_t          in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output gosd_cmd_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  gosd_coord_t      pen_x_r;
  gosd_coord_t      pen_y_r;
  logic             fill_cw_r;
  logic             pt_valid;
  gosd_point_t      pt;
  logic             take;
  gosd_batch_t      batch;
  gosd_drain_stat_t drain_stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      fill_cw_r <= 1'b1;
    end else if (cfg_we) begin
      case (gosd_cfg_idx_t'(cfg_index))
        CFG_PEN_X:   pen_x_r   <= gosd_coord_t'(cfg_wdata);
        CFG_PEN_Y:   pen_y_r   <= gosd_coord_t'(cfg_wdata);
        CFG_FILL_CW: fill_cw_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  gosd_point_reg u_point_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pen_x    (pen_x_r),
    .pen_y    (pen_y_r),
    .take     (take),
    .pt_valid (pt_valid),
    .pt       (pt)
  );

  gosd_seg_decode u_seg_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (pt_valid),
    .pt         (pt),
    .fill_cw    (fill_cw_r),
    .drain_stat (drain_stat),
    .take       (take),
    .batch      (batch)
  );

  gosd_cmd_drain u_cmd_drain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .batch     (batch),
    .stat      (drain_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The run marker sits exactly on the last queued command
  a_last_marks_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_run == (drain_stat.count == 2'd1)))
    else $error("last_of_run does not match queue tail");

  // Closing commands carry no end point
  a_close_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.command == CMD_CLOSE_LINE ||
                  out_data.command == CMD_CLOSE_QUAD ||
                  out_data.command == CMD_CLOSE_CUBIC)
    |-> (out_data.end_x == '0 && out_data.end_y == '0))
    else $error("close command with nonzero end point");

  // Fill direction only travels with a contour start
  a_fill_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.command != CMD_START |-> !out_data.clockwise_fill)
    else $error("fill direction set on non-start command");

  // A taken point leaves the decoder with the queue loaded or with no output
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    take && batch.count != '0 |=> out_valid)
    else $error("decoded commands not queued");

endmodule

`default_nettype wire

// ===== rtl/core/gosd_point_reg.sv =====
// ----------------------------------------------------------------------------
// gosd_point_reg
// Input register: takes one point request, adds the pen offset and holds the
// translated point until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gosd_point_reg
  import gosd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire gosd_point_t in_data,
  input  wire gosd_coord_t pen_x,
  input  wire gosd_coord_t pen_y,
  input  wire logic        take,
  output logic             pt_valid,
  output gosd_point_t      pt
);

  logic        valid_r;
  logic        valid_nxt;
  gosd_point_t pt_r;
  gosd_point_t pt_nxt;
  logic        accept;

  // Open when empty or when the held point leaves this cycle
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  // Translate the incoming point
  always_comb begin
    pt_nxt         = pt_r;
    pt_nxt.point_x = in_data.point_x + pen_x;
    pt_nxt.point_y = in_data.point_y + pen_y;
    pt_nxt.on_curve      = in_data.on_curve;
    pt_nxt.cubic_control = in_data.cubic_control;
    pt_nxt.contour_end   = in_data.contour_end;
  end

  assign valid_nxt = accept ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_r <= pt_nxt;
    end
  end

  assign pt_valid = valid_r;
  assign pt       = pt_r;

endmodule

`default_nettype wire

// ===== rtl/core/gosd_seg_decode.sv =====
// ----------------------------------------------------------------------------
// gosd_seg_decode
// Contour walker: tracks the phase and held controls, and turns one point
// into up to three drawing commands combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module gosd_seg_decode
  import gosd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pt_valid,
  input  wire gosd_point_t      pt,
  input  wire logic             fill_cw,
  input  wire gosd_drain_stat_t drain_stat,
  output logic                  take,
  output gosd_batch_t           batch
);

  gosd_phase_t phase_r;
  gosd_phase_t phase_nxt;
  gosd_coord_t h1x_r, h1y_r, h2x_r, h2y_r;
  gosd_coord_t h1x_nxt, h1y_nxt, h2x_nxt, h2y_nxt;
  logic        h2cub_r;
  logic        h2cub_nxt;

  gosd_cmd_t [MAX_CMDS-1:0] res_c;
  logic [CNT_W-1:0]         n_c;
  logic                     to_on;
  gosd_coord_t              x, y;
  logic                     on, cub, fin;

  assign take = pt_valid && drain_stat.load_ok;

  assign x   = pt.point_x;
  assign y   = pt.point_y;
  assign on  = pt.on_curve;
  assign cub = pt.cubic_control;
  assign fin = pt.contour_end;

  // Build the commands for this point
  always_comb begin
    res_c     = '0;
    n_c       = '0;
    to_on     = 1'b0;
    phase_nxt = phase_r;
    h1x_nxt   = h1x_r;
    h1y_nxt   = h1y_r;
    h2x_nxt   = h2x_r;
    h2y_nxt   = h2y_r;
    h2cub_nxt = h2cub_r;

    unique case (phase_r)
      PH_SEEK: begin
        // First point of a contour counts as on-curve whatever its tags
        res_c[0] = gosd_make_cmd(CMD_START, x, y, '0, '0, '0, '0, fill_cw);
        n_c      = 2'd1;
        to_on    = 1'b1;
      end
      PH_ON: begin
        if (on) begin
          res_c[0] = gosd_make_cmd(CMD_LINE, x, y, '0, '0, '0, '0, 1'b0);
          n_c      = 2'd1;
          to_on    = 1'b1;
        end else if (fin) begin
          res_c[0]  = gosd_make_cmd(CMD_CLOSE_QUAD, '0, '0, x, y, '0, '0, 1'b0);
          n_c       = 2'd1;
          phase_nxt = PH_SEEK;
        end else begin
          h1x_nxt   = x;
          h1y_nxt   = y;
          phase_nxt = PH_CTRL1;
        end
      end
      PH_CTRL1: begin
        if (on) begin
          res_c[0] = gosd_make_cmd(CMD_QUAD, x, y, h1x_r, h1y_r, '0, '0, 1'b0);
          n_c      = 2'd1;
          to_on    = 1'b1;
        end else if (fin) begin
          if (cub) begin
            res_c[0] = gosd_make_cmd(CMD_CLOSE_CUBIC, '0, '0, h1x_r, h1y_r, x, y, 1'b0);
            n_c      = 2'd1;
          end else begin
            // Second control conic: split the two controls at their midpoint, then close
            res_c[0] = gosd_make_cmd(CMD_QUAD, gosd_mid(h1x_r, x), gosd_mid(h1y_r, y),
                                     h1x_r, h1y_r, '0, '0, 1'b0);
            res_c[1] = gosd_make_cmd(CMD_CLOSE_QUAD, '0, '0, x, y, '0, '0, 1'b0);
            n_c      = 2'd2;
          end
          phase_nxt = PH_SEEK;
        end else begin
          h2x_nxt   = x;
          h2y_nxt   = y;
          h2cub_nxt = cub;
          phase_nxt = PH_CTRL2;
        end
      end
      PH_CTRL2: begin
        // Point after two controls is taken as an end point
        if (h2cub_r) begin
          res_c[0] = gosd_make_cmd(CMD_CUBIC, x, y, h1x_r, h1y_r, h2x_r, h2y_r, 1'b0);
          n_c      = 2'd1;
        end else begin
          res_c[0] = gosd_make_cmd(CMD_QUAD, gosd_mid(h1x_r, h2x_r), gosd_mid(h1y_r, h2y_r),
                                   h1x_r, h1y_r, '0, '0, 1'b0);
          res_c[1] = gosd_make_cmd(CMD_QUAD, x, y, h2x_r, h2y_r, '0, '0, 1'b0);
          n_c      = 2'd2;
        end
        to_on = 1'b1;
      end
      default: begin
        phase_nxt = PH_SEEK;
      end
    endcase

    // Close by line when a contour ends on an end point
    if (to_on) begin
      if (fin) begin
        res_c[n_c] = gosd_make_cmd(CMD_CLOSE_LINE, '0, '0, '0, '0, '0, '0, 1'b0);
        n_c        = n_c + 2'd1;
        phase_nxt  = PH_SEEK;
      end else begin
        phase_nxt  = PH_ON;
      end
    end

    // Mark the final command of the run
    if (n_c != '0) begin
      res_c[n_c - 2'd1].last_of_run = 1'b1;
    end
  end

  assign batch.count = n_c;
  assign batch.cmds  = res_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h1x_r   <= h1x_nxt;
      h1y_r   <= h1y_nxt;
      h2x_r   <= h2x_nxt;
      h2y_r   <= h2y_nxt;
      h2cub_r <= h2cub_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gosd_cmd_drain.sv =====
// ----------------------------------------------------------------------------
// gosd_cmd_drain
// Result queue: loads the commands of one point and hands them out one per
// cycle while out_ready is high, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module gosd_cmd_drain
  import gosd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire gosd_batch_t batch,
  output gosd_drain_stat_t stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output gosd_cmd_t        out_data
);

  gosd_cmd_t [MAX_CMDS-1:0] slot_r;
  gosd_cmd_t [MAX_CMDS-1:0] slot_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && out_ready;

  // Accept a new batch when empty or when the last command leaves now
  assign stat.load_ok = (cnt_r == '0) || (pop && cnt_r == 2'd1);
  assign stat.count   = cnt_r;

  // Load a batch or advance the queue
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = batch.cmds;
      cnt_nxt  = batch.count;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph outline segment decoder. A directed table
// walks every command, the extreme coordinates and the odd contour shapes.
// Random contours follow under several pen offsets and fill settings. Each
// accepted point runs through a local decoder model, and every command that
// comes out is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gosd_pkg::*;

  localparam gosd_coord_t NO_COORD = '0;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 8;

  // Local view of where the decoder stands within a contour
  typedef enum logic [1:0] {
    CS_AWAIT    = 2'd0,
    CS_ON       = 2'd1,
    CS_ONE_CTRL = 2'd2,
    CS_TWO_CTRL = 2'd3
  } contour_state_t;

  typedef struct packed {
    gosd_point_t pt;
    logic        typed;
    gosd_cmd_t   want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  gosd_point_t in_data;
  logic out_valid;
  logic out_ready;
  gosd_cmd_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // Decoder model state and its copy of the registers
  contour_state_t walk_q = CS_AWAIT;
  gosd_coord_t held_a_x = '0;
  gosd_coord_t held_a_y = '0;
  gosd_coord_t held_b_x = '0;
  gosd_coord_t held_b_y = '0;
  logic held_b_cubic = 1'b0;
  gosd_coord_t pen_x_now = '0;
  gosd_coord_t pen_y_now = '0;
  logic fill_cw_now = 1'b1;

  gosd_cmd_t point_cmds[$];
  gosd_cmd_t pending_cmds[$];
  stim_row_t directed_rows[$];

  bit steady_flow = 1'b0;
  bit hold_off_req = 1'b0;
  int contour_left = 0;
  int points_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int mismatch_count = 0;
  int cmd_seen[7];

  glyph_outline_segment_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic gosd_cmd_t make_cmd(
    input gosd_cmd_code_t code,
    input gosd_coord_t    ex,
    input gosd_coord_t    ey,
    input gosd_coord_t    c1x,
    input gosd_coord_t    c1y,
    input gosd_coord_t    c2x,
    input gosd_coord_t    c2y,
    input logic           cw,
    input logic           last
  );
    gosd_cmd_t c;
    c.command        = code;
    c.end_x          = ex;
    c.end_y          = ey;
    c.first_ctrl_x   = c1x;
    c.first_ctrl_y   = c1y;
    c.second_ctrl_x  = c2x;
    c.second_ctrl_y  = c2y;
    c.clockwise_fill = cw;
    c.last_of_run    = last;
    return c;
  endfunction

  // Wrapped sum of two coordinates, halved with the sign kept
  function automatic gosd_coord_t split_mid(input gosd_coord_t a, input gosd_coord_t b);
    gosd_coord_t s;
    s = a + b;
    return s >>> 1;
  endfunction

  function automatic gosd_point_t make_point(
    input gosd_coord_t x,
    input gosd_coord_t y,
    input logic        on,
    input logic        cub,
    input logic        fin
  );
    gosd_point_t p;
    p.point_x       = x;
    p.point_y       = y;
    p.on_curve      = on;
    p.cubic_control = cub;
    p.contour_end   = fin;
    return p;
  endfunction

  // Small values half the time, with extremes and full-width values mixed in
  function automatic gosd_coord_t pick_coord();
    gosd_coord_t v;
    case ($urandom_range(9))
      0: v = 32'sh7FFF_FFFF;
      1: v = 32'sh8000_0000;
      2, 3, 4: v = $urandom;
      default: begin
        v = $urandom_range(2000);
        v = v - 32'sd1000;
      end
    endcase
    return v;
  endfunction

  // Work out the commands one accepted point causes, and advance the model
  task automatic decode_point(input gosd_point_t p);
    gosd_coord_t x;
    gosd_coord_t y;
    contour_state_t nxt;
    x = p.point_x + pen_x_now;
    y = p.point_y + pen_y_now;
    nxt = CS_ON;
    point_cmds.delete();
    case (walk_q)
      CS_AWAIT: begin
        point_cmds.push_back(make_cmd(CMD_START, x, y, NO_COORD, NO_COORD,
                                      NO_COORD, NO_COORD, fill_cw_now, 1'b0));
      end
      CS_ON: begin
        if (p.on_curve) begin
          point_cmds.push_back(make_cmd(CMD_LINE, x, y, NO_COORD, NO_COORD,
                                        NO_COORD, NO_COORD, 1'b0, 1'b0));
        end else if (p.contour_end) begin
          point_cmds.push_back(make_cmd(CMD_CLOSE_QUAD, NO_COORD, NO_COORD, x, y,
                                        NO_COORD, NO_COORD, 1'b0, 1'b0));
          nxt = CS_AWAIT;
        end else begin
          held_a_x = x;
          held_a_y = y;
          nxt = CS_ONE_CTRL;
        end
      end
      CS_ONE_CTRL: begin
        if (p.on_curve) begin
          point_cmds.push_back(make_cmd(CMD_QUAD, x, y, held_a_x, held_a_y,
                                        NO_COORD, NO_COORD, 1'b0, 1'b0));
        end else if (p.contour_end) begin
          if (p.cubic_control) begin
            point_cmds.push_back(make_cmd(CMD_CLOSE_CUBIC, NO_COORD, NO_COORD,
                                          held_a_x, held_a_y, x, y, 1'b0, 1'b0));
          end else begin
            point_cmds.push_back(make_cmd(CMD_QUAD, split_mid(held_a_x, x),
                                          split_mid(held_a_y, y), held_a_x, held_a_y,
                                          NO_COORD, NO_COORD, 1'b0, 1'b0));
            point_cmds.push_back(make_cmd(CMD_CLOSE_QUAD, NO_COORD, NO_COORD, x, y,
                                          NO_COORD, NO_COORD, 1'b0, 1'b0));
          end
          nxt = CS_AWAIT;
        end else begin
          held_b_x = x;
          held_b_y = y;
          held_b_cubic = p.cubic_control;
          nxt = CS_TWO_CTRL;
        end
      end
      default: begin
        // whatever its tags, the point after two controls ends the segment
        if (held_b_cubic) begin
          point_cmds.push_back(make_cmd(CMD_CUBIC, x, y, held_a_x, held_a_y,
                                        held_b_x, held_b_y, 1'b0, 1'b0));
        end else begin
          point_cmds.push_back(make_cmd(CMD_QUAD, split_mid(held_a_x, held_b_x),
                                        split_mid(held_a_y, held_b_y), held_a_x, held_a_y,
                                        NO_COORD, NO_COORD, 1'b0, 1'b0));
          point_cmds.push_back(make_cmd(CMD_QUAD, x, y, held_b_x, held_b_y,
                                        NO_COORD, NO_COORD, 1'b0, 1'b0));
        end
      end
    endcase
    if (nxt == CS_ON && p.contour_end) begin
      point_cmds.push_back(make_cmd(CMD_CLOSE_LINE, NO_COORD, NO_COORD, NO_COORD,
                                    NO_COORD, NO_COORD, NO_COORD, 1'b0, 1'b0));
      nxt = CS_AWAIT;
    end
    walk_q = nxt;
    if (point_cmds.size() > 0)
      point_cmds[point_cmds.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at command %0d: %s", results_checked, what);
  endtask

  task automatic check_cmd(input gosd_cmd_t got, input gosd_cmd_t want);
    if (got.command !== want.command)
      flag_mismatch($sformatf("command got %0d want %0d", got.command, want.command));
    if (got.end_x !== want.end_x)
      flag_mismatch($sformatf("end_x got %h want %h", got.end_x, want.end_x));
    if (got.end_y !== want.end_y)
      flag_mismatch($sformatf("end_y got %h want %h", got.end_y, want.end_y));
    if (got.first_ctrl_x !== want.first_ctrl_x)
      flag_mismatch($sformatf("first_ctrl_x got %h want %h",
                              got.first_ctrl_x, want.first_ctrl_x));
    if (got.first_ctrl_y !== want.first_ctrl_y)
      flag_mismatch($sformatf("first_ctrl_y got %h want %h",
                              got.first_ctrl_y, want.first_ctrl_y));
    if (got.second_ctrl_x !== want.second_ctrl_x)
      flag_mismatch($sformatf("second_ctrl_x got %h want %h",
                              got.second_ctrl_x, want.second_ctrl_x));
    if (got.second_ctrl_y !== want.second_ctrl_y)
      flag_mismatch($sformatf("second_ctrl_y got %h want %h",
                              got.second_ctrl_y, want.second_ctrl_y));
    if (got.clockwise_fill !== want.clockwise_fill)
      flag_mismatch($sformatf("clockwise_fill got %b want %b",
                              got.clockwise_fill, want.clockwise_fill));
    if (got.last_of_run !== want.last_of_run)
      flag_mismatch($sformatf("last_of_run got %b want %b",
                              got.last_of_run, want.last_of_run));
  endtask

  // Offer one point, hold it until accepted, then predict its commands
  task automatic offer_point(input gosd_point_t p, input logic typed, input gosd_cmd_t want);
    if (!steady_flow && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    decode_point(p);
    if (typed)
      pending_cmds.push_back(want);
    else
      foreach (point_cmds[k]) pending_cmds.push_back(point_cmds[k]);
  endtask

  // Stop sending and wait until every predicted command has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles; block must be idle
  task automatic set_pen_fill(input gosd_coord_t px, input gosd_coord_t py, input logic cw);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PEN_X;
    cfg_wdata <= px;
    @(posedge clk);
    cfg_index <= CFG_PEN_Y;
    cfg_wdata <= py;
    @(posedge clk);
    cfg_index <= CFG_FILL_CW;
    cfg_wdata <= {{(CFG_W-1){1'b0}}, cw};
    @(posedge clk);
    cfg_we <= 1'b0;
    pen_x_now = px;
    pen_y_now = py;
    fill_cw_now = cw;
    cfg_writes += 3;
  endtask

  // Mostly well-formed contours; phases may end in the middle of one
  task automatic random_points(input int count);
    gosd_point_t p;
    for (int n = 0; n < count; n++) begin
      if (contour_left == 0)
        contour_left = ($urandom_range(9) == 0) ? $urandom_range(7, 12)
                                                : $urandom_range(1, 5);
      if ($urandom_range(99) < 10)
        p = make_point(pick_coord(), pick_coord(), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        p = make_point(pick_coord(), pick_coord(), $urandom_range(99) < 45,
                       1'($urandom_range(1)), contour_left == 1);
      contour_left--;
      offer_point(p, 1'b0, '0);
    end
  endtask

  task automatic add_row(input gosd_point_t p, input logic typed, input gosd_cmd_t want);
    stim_row_t r;
    r.pt    = p;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  // Receiver: random back-pressure (none in steady flow), or a long hold-off when asked
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 18);
      end
    end
  end

  // Check every command that leaves the block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch("command arrived with none predicted");
      end else begin
        check_cmd(out_data, pending_cmds.pop_front());
      end
      if (out_data.command <= CMD_CLOSE_CUBIC)
        cmd_seen[out_data.command]++;
      results_checked++;
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PEN_X;
    cfg_wdata = '0;
    rst_n     = 1'b0;

    // Directed table, run with the reset pen and fill
    add_row(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b1, 1'b0), 1'b1,
            make_cmd(CMD_START, 32'sh7FFF_FFFF, 32'sh8000_0000, NO_COORD, NO_COORD,
                     NO_COORD, NO_COORD, 1'b1, 1'b1));
    add_row(make_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0), 1'b1,
            make_cmd(CMD_LINE, 32'sh8000_0000, 32'sh7FFF_FFFF, NO_COORD, NO_COORD,
                     NO_COORD, NO_COORD, 1'b0, 1'b1));
    add_row(make_point(32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0000, 32'shFFFF_FFFF, 1'b1, 1'b0, 1'b0), 1'b0, '0);
    // first control tagged cubic, second conic: split at a wrapping midpoint
    add_row(make_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0010, 32'sh0000_0020, 1'b1, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_1000, 32'shFFFF_F000, 1'b0, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0003, 32'sh0000_0005, 1'b1, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_point(32'shFFFF_FFFE, 32'sh0000_0007, 1'b1, 1'b0, 1'b1), 1'b0, '0);
    // contour closed through a single control
    add_row(make_point(32'sh0000_0001, 32'sh0000_0002, 1'b1, 1'b0, 1'b0), 1'b1,
            make_cmd(CMD_START, 32'sh0000_0001, 32'sh0000_0002, NO_COORD, NO_COORD,
                     NO_COORD, NO_COORD, 1'b1, 1'b1));
    add_row(make_point(32'sh1234_5678, 32'sh9ABC_DEF0, 1'b0, 1'b0, 1'b1), 1'b1,
            make_cmd(CMD_CLOSE_QUAD, NO_COORD, NO_COORD, 32'sh1234_5678, 32'sh9ABC_DEF0,
                     NO_COORD, NO_COORD, 1'b0, 1'b1));
    // closed through two controls, cubic then conic
    add_row(make_point(32'sh0000_0011, 32'sh0000_0022, 1'b1, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0033, 32'sh0000_0044, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0055, 32'sh0000_0066, 1'b0, 1'b1, 1'b1), 1'b0, '0);
    add_row(make_point(32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, 1'b0, 1'b1), 1'b0, '0);
    // single-point contour
    add_row(make_point(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 1'b1, 1'b1), 1'b0, '0);
    // off-curve closing point after two conic controls: two quads and a close
    add_row(make_point(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0100, 32'sh0000_0200, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0300, 32'sh0000_0400, 1'b0, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_point(32'sh0000_0500, 32'sh0000_0600, 1'b0, 1'b1, 1'b1), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // extreme pens, reverse fill, no idling on either side
    set_pen_fill(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    steady_flow = 1'b1;
    random_points(40);
    drain_results();
    steady_flow = 1'b0;

    // opposite extremes; the sink holds off while points keep coming
    set_pen_fill(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    random_points(15);
    hold_off_req = 1'b1;
    random_points(25);
    drain_results();

    // random pens; pause mid-phase until every command is out
    set_pen_fill($urandom, $urandom, 1'b0);
    random_points(20);
    drain_results();
    random_points(20);
    drain_results();

    set_pen_fill(NO_COORD, NO_COORD, 1'b1);
    random_points(40);
    drain_results();

    set_pen_fill($urandom, $urandom, 1'($urandom_range(1)));
    random_points(40);
    drain_results();

    $display("%0d points sent, %0d commands checked, %0d register writes",
             points_sent, results_checked, cfg_writes);
    $display("start %0d line %0d quad %0d cubic %0d close line %0d quad %0d cubic %0d",
             cmd_seen[CMD_START], cmd_seen[CMD_LINE], cmd_seen[CMD_QUAD],
             cmd_seen[CMD_CUBIC], cmd_seen[CMD_CLOSE_LINE], cmd_seen[CMD_CLOSE_QUAD],
             cmd_seen[CMD_CLOSE_CUBIC]);
    if (mismatch_count == 0 && pending_cmds.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
